// ===== sv/pidc_pkg.sv =====
// Package for the PID controller (positional and incremental forms).
// Holds field widths, register index codes and the payload and config structs.
// No dependencies.
package pidc_pkg;

	localparam int DATA_WIDTH      = 16;
	localparam int ERR_WIDTH       = DATA_WIDTH + 1;
	localparam int GAIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 24;
	localparam int DRIVE_WIDTH     = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = LIMIT_WIDTH;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP           = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI           = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD           = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_MAX      = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_MIN      = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLAMP_ENABLE = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE         = 3'd6;

	localparam logic MODE_INCREMENTAL = 1'b0;
	localparam logic MODE_POSITIONAL  = 1'b1;

	// Reset values of the registers
	localparam logic signed [GAIN_WIDTH-1:0]  KP_RESET      = 16'sd23040;
	localparam logic signed [GAIN_WIDTH-1:0]  KI_RESET      = 16'sd3840;
	localparam logic signed [GAIN_WIDTH-1:0]  KD_RESET      = 16'sd0;
	localparam logic signed [LIMIT_WIDTH-1:0] OUT_MAX_RESET = 24'sd1000;
	localparam logic signed [LIMIT_WIDTH-1:0] OUT_MIN_RESET = -24'sd1000;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] setpoint;
		logic signed [DATA_WIDTH-1:0] measured;
	} pidc_sample_t;

	typedef struct packed {
		logic signed [DRIVE_WIDTH-1:0] drive;
		logic                          limited;
	} pidc_result_t;

	typedef struct packed {
		logic signed [GAIN_WIDTH-1:0]  kp;
		logic signed [GAIN_WIDTH-1:0]  ki;
		logic signed [GAIN_WIDTH-1:0]  kd;
		logic signed [LIMIT_WIDTH-1:0] out_max;
		logic signed [LIMIT_WIDTH-1:0] out_min;
		logic                          clamp_enable;
		logic                          mode;
	} pidc_cfg_t;

endpackage

// ===== sv/pidc_core.sv =====
// PID datapath: error differences, integrator update, three gain products,
// 32-bit saturation and output clamping. Purely combinational.
// Depends on pidc_pkg.
module pidc_core
	import pidc_pkg::*;
#(
	parameter int SUM_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  pidc_cfg_t                     cfg,
	input  logic signed [ERR_WIDTH-1:0]   err,
	input  logic signed [ERR_WIDTH-1:0]   prev_err,
	input  logic signed [ERR_WIDTH-1:0]   prev2_err,
	input  logic signed [SUM_WIDTH-1:0]   err_sum,
	output logic signed [SUM_WIDTH-1:0]   sum_next,
	output pidc_result_t                  result
);

	localparam int D1_W  = ERR_WIDTH + 1;
	localparam int D2_W  = ERR_WIDTH + 2;
	localparam int SX_W  = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + 1;
	localparam int OP_W  = (SUM_WIDTH > D2_W) ? SUM_WIDTH : D2_W;
	localparam int PR_W  = OP_W + GAIN_WIDTH;
	localparam int ACC_W = PR_W + 2;

	localparam logic signed [SX_W-1:0] SUM_HI =
		{{(SX_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SX_W-1:0] SUM_LO =
		{{(SX_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] DRV_HI =
		{{(ACC_W-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] DRV_LO =
		{{(ACC_W-DRIVE_WIDTH+1){1'b1}}, {(DRIVE_WIDTH-1){1'b0}}};

	logic signed [GAIN_WIDTH-1:0]  kp, ki, kd;
	logic signed [DRIVE_WIDTH-1:0] lim_hi, lim_lo;
	logic signed [D1_W-1:0]        d1;
	logic signed [D2_W-1:0]        d2;
	logic signed [SX_W-1:0]        sum_ext;
	logic signed [OP_W-1:0]        op_p, op_i, op_d;
	logic signed [PR_W-1:0]        prod_p, prod_i, prod_d;
	logic signed [ACC_W-1:0]       acc, acc_sat;
	logic signed [DRIVE_WIDTH-1:0] res;

	always_comb begin
		kp     = cfg.kp;
		ki     = cfg.ki;
		kd     = cfg.kd;
		lim_hi = DRIVE_WIDTH'(cfg.out_max);
		lim_lo = DRIVE_WIDTH'(cfg.out_min);

		d1 = D1_W'(err) - D1_W'(prev_err);
		d2 = D2_W'(err) - (D2_W'(prev_err) <<< 1) + D2_W'(prev2_err);

		// integrator, saturating at SUM_WIDTH bits
		sum_ext = SX_W'(err_sum) + SX_W'(err);
		if (sum_ext > SUM_HI) begin
			sum_next = SUM_HI[SUM_WIDTH-1:0];
		end else if (sum_ext < SUM_LO) begin
			sum_next = SUM_LO[SUM_WIDTH-1:0];
		end else begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end

		if (cfg.mode == MODE_POSITIONAL) begin
			op_p = OP_W'(err);
			op_i = OP_W'(sum_next);
			op_d = OP_W'(d1);
		end else begin
			op_p = OP_W'(d1);
			op_i = OP_W'(err);
			op_d = OP_W'(d2);
		end

		prod_p = PR_W'(kp) * op_p;
		prod_i = PR_W'(ki) * op_i;
		prod_d = PR_W'(kd) * op_d;

		// arithmetic shift floors toward minus infinity
		acc = ACC_W'(prod_p >>> GAIN_FRAC_BITS) + ACC_W'(prod_i >>> GAIN_FRAC_BITS)
			+ ACC_W'(prod_d >>> GAIN_FRAC_BITS);

		if (acc > DRV_HI) begin
			acc_sat = DRV_HI;
		end else if (acc < DRV_LO) begin
			acc_sat = DRV_LO;
		end else begin
			acc_sat = acc;
		end
		res = acc_sat[DRIVE_WIDTH-1:0];

		// crossed limits: out_min is applied last and wins
		if (cfg.clamp_enable) begin
			if (res > lim_hi) begin
				res = lim_hi;
			end
			if (res < lim_lo) begin
				res = lim_lo;
			end
		end

		result.drive   = res;
		result.limited = (ACC_W'(res) != acc);
	end

endmodule

// ===== sv/pid_controller_pos_inc.sv =====
// PID controller, positional and incremental forms, one result per sample.
// A transferred sample's error is registered in stage 1; the core result then loads
// the result register when it is empty or draining, and transfers out from there.
// Throughput: one sample per cycle unless the result channel stalls; the only
// loop (error history and integrator update) closes in the single datapath stage.
// Reset (arst_n low): gains and limits return to defaults, history and
// integrator clear to zero, both pipeline stages empty.
module pid_controller_pos_inc
	import pidc_pkg::*;
#(
	parameter int SUM_WIDTH      = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	// sample channel
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  pidc_sample_t               sample,
	// result channel
	output logic                       result_valid,
	input  logic                       result_ready,
	output pidc_result_t               result
);

	// Configuration registers
	pidc_cfg_t cfg_q;

	// Stage 1: error of the accepted sample
	logic                        valid_s1;
	logic signed [ERR_WIDTH-1:0] err_s1;
	logic signed [ERR_WIDTH-1:0] err_in;

	// Controller history
	logic signed [ERR_WIDTH-1:0] prev_err_q;
	logic signed [ERR_WIDTH-1:0] prev2_err_q;
	logic signed [SUM_WIDTH-1:0] err_sum_q;

	// Result register
	logic         rsp_valid_q;
	pidc_result_t rsp_q;

	logic                        adv_s1;
	logic signed [SUM_WIDTH-1:0] sum_next;
	pidc_result_t                core_result;

	// Configuration writes; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp           <= KP_RESET;
			cfg_q.ki           <= KI_RESET;
			cfg_q.kd           <= KD_RESET;
			cfg_q.out_max      <= OUT_MAX_RESET;
			cfg_q.out_min      <= OUT_MIN_RESET;
			cfg_q.clamp_enable <= 1'b1;
			cfg_q.mode         <= MODE_INCREMENTAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:           cfg_q.kp           <= cfg_data[GAIN_WIDTH-1:0];
				REG_KI:           cfg_q.ki           <= cfg_data[GAIN_WIDTH-1:0];
				REG_KD:           cfg_q.kd           <= cfg_data[GAIN_WIDTH-1:0];
				REG_OUT_MAX:      cfg_q.out_max      <= cfg_data[LIMIT_WIDTH-1:0];
				REG_OUT_MIN:      cfg_q.out_min      <= cfg_data[LIMIT_WIDTH-1:0];
				REG_CLAMP_ENABLE: cfg_q.clamp_enable <= cfg_data[0];
				REG_MODE:         cfg_q.mode         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance stage 1 when the result register is empty or being drained.
	// The result register parts the channels, so a stalled result still
	// lets one more sample sit in stage 1.
	assign adv_s1       = valid_s1 && (!rsp_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;

	// Form the error on the way in; it fits ERR_WIDTH bits exactly
	assign err_in = ERR_WIDTH'(sample.setpoint) - ERR_WIDTH'(sample.measured);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			err_s1 <= err_in;
		end
	end

	pidc_core #(
		.SUM_WIDTH      (SUM_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.cfg       (cfg_q),
		.err       (err_s1),
		.prev_err  (prev_err_q),
		.prev2_err (prev2_err_q),
		.err_sum   (err_sum_q),
		.sum_next  (sum_next),
		.result    (core_result)
	);

	// Shift the error history in both modes; the integrator moves only in
	// positional mode and holds its value in incremental mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			prev2_err_q <= '0;
			err_sum_q   <= '0;
		end else if (adv_s1) begin
			prev2_err_q <= prev_err_q;
			prev_err_q  <= err_s1;
			if (cfg_q.mode == MODE_POSITIONAL) begin
				err_sum_q <= sum_next;
			end
		end
	end

	// Result register: load on advance, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (result_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= core_result;
		end
	end

	assign result_valid = rsp_valid_q;
	assign result       = rsp_q;

	// An empty result register never blocks the sample channel
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> sample_ready)
		else $error("sample_ready low with empty result register");

	// A stalled result keeps stage 1 occupied
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !result_ready) |=> valid_s1)
		else $error("stage 1 lost its sample during a result stall");

	// Error history shifts by one on every advance
	a_history_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (prev2_err_q == $past(prev_err_q)) && (prev_err_q == $past(err_s1)))
		else $error("error history did not shift");

	// Incremental mode leaves the integrator alone
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (cfg_q.mode == MODE_INCREMENTAL)) |=> $stable(err_sum_q))
		else $error("integrator moved in incremental mode");

endmodule

// ===== dv/pidc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PID controller: watches the config port and both channels,
// predicts each result and compares it. Depends on pidc_pkg.
module pidc_checker
	import pidc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                       sample_valid,
	input  logic                       sample_ready,
	input  pidc_sample_t               sample,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  pidc_result_t               result,
	output int                         fail_count,
	output int                         pending
);

	localparam int SUM_BITS   = 32;
	localparam int FRAC_BITS  = 8;
	localparam int PRINT_CAP  = 50;
	localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
	localparam longint SUM_LO = -(longint'(1) <<< (SUM_BITS - 1));
	localparam longint OUT_HI = (longint'(1) <<< (DRIVE_WIDTH - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) <<< (DRIVE_WIDTH - 1));

	pidc_cfg_t                    regs;
	logic signed [ERR_WIDTH-1:0]  err_d1;
	logic signed [ERR_WIDTH-1:0]  err_d2;
	logic signed [SUM_BITS-1:0]   integ;
	pidc_result_t                 drive_q[$];
	int                           n_results;

	function automatic longint floor_q(input longint x);
		return x >>> FRAC_BITS;
	endfunction

	task automatic log_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("[chk] mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Advance the controller model by one sample and return its output.
	task automatic predict_drive(input pidc_sample_t s, output pidc_result_t r);
		longint err, e1, e2, gp, gi, gd, sum, acc, res;
		err = longint'($signed(s.setpoint)) - longint'($signed(s.measured));
		e1  = longint'(err_d1);
		e2  = longint'(err_d2);
		gp  = longint'($signed(regs.kp));
		gi  = longint'($signed(regs.ki));
		gd  = longint'($signed(regs.kd));
		if (regs.mode == MODE_POSITIONAL) begin
			sum = longint'(integ) + err;
			if (sum > SUM_HI) sum = SUM_HI;
			if (sum < SUM_LO) sum = SUM_LO;
			integ = sum[SUM_BITS-1:0];
			acc = floor_q(gp * err) + floor_q(gi * sum) + floor_q(gd * (err - e1));
		end else begin
			acc = floor_q(gp * (err - e1)) + floor_q(gi * err)
				+ floor_q(gd * (err - 2 * e1 + e2));
		end
		err_d2 = err_d1;
		err_d1 = err[ERR_WIDTH-1:0];
		res = acc;
		if (res > OUT_HI) res = OUT_HI;
		if (res < OUT_LO) res = OUT_LO;
		if (regs.clamp_enable) begin
			if (res > longint'($signed(regs.out_max))) res = longint'($signed(regs.out_max));
			if (res < longint'($signed(regs.out_min))) res = longint'($signed(regs.out_min));
		end
		r.drive   = res[DRIVE_WIDTH-1:0];
		r.limited = (res != acc);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pidc_result_t got, want;
		if (!arst_n) begin
			regs.kp           = KP_RESET;
			regs.ki           = KI_RESET;
			regs.kd           = KD_RESET;
			regs.out_max      = OUT_MAX_RESET;
			regs.out_min      = OUT_MIN_RESET;
			regs.clamp_enable = 1'b1;
			regs.mode         = MODE_INCREMENTAL;
			err_d1            = '0;
			err_d2            = '0;
			integ             = '0;
			drive_q.delete();
			n_results         = 0;
			fail_count        = 0;
			pending           = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP:           regs.kp           = cfg_data[GAIN_WIDTH-1:0];
					REG_KI:           regs.ki           = cfg_data[GAIN_WIDTH-1:0];
					REG_KD:           regs.kd           = cfg_data[GAIN_WIDTH-1:0];
					REG_OUT_MAX:      regs.out_max      = cfg_data[LIMIT_WIDTH-1:0];
					REG_OUT_MIN:      regs.out_min      = cfg_data[LIMIT_WIDTH-1:0];
					REG_CLAMP_ENABLE: regs.clamp_enable = cfg_data[0];
					REG_MODE:         regs.mode         = cfg_data[0];
					default: ;
				endcase
			end
			// Compare before predicting so a result can never match its own sample.
			if (result_valid && result_ready) begin
				got = result;
				if (drive_q.size() == 0) begin
					log_mismatch($sformatf("result %0d (drive %0d) with nothing predicted",
						n_results, got.drive));
				end else begin
					want = drive_q.pop_front();
					if (got.drive !== want.drive)
						log_mismatch($sformatf("result %0d: drive %0d, predicted %0d",
							n_results, got.drive, want.drive));
					if (got.limited !== want.limited)
						log_mismatch($sformatf("result %0d: limited %b, predicted %b",
							n_results, got.limited, want.limited));
				end
				n_results++;
			end
			if (sample_valid && sample_ready) begin
				predict_drive(sample, want);
				drive_q.push_back(want);
			end
			pending = drive_q.size();
		end
	end

endmodule

// ===== dv/tb_pid_controller_pos_inc.sv =====
`timescale 1ns / 100ps
// PID controller testbench top: clock, reset, config writes, samples and result
// back-pressure. Depends on pidc_pkg, pidc_checker, pid_controller_pos_inc.
module tb_pid_controller_pos_inc;
	import pidc_pkg::*;

	// Index with no register behind it; writes there must be dropped.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 6;   // pipeline is two stages deep
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int WINDUP_UP     = 270;
	localparam int WINDUP_DOWN   = 540;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 25;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic                       sample_valid = 1'b0;
	logic                       sample_ready;
	pidc_sample_t               sample = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	pidc_result_t               result;
	int                         fail_count;
	int                         pending;

	int   idle_pct = 0;         // chance per cycle that the sender holds off
	int   stall_pct = 0;        // chance per cycle that the receiver stalls
	logic hold_request = 1'b0;  // ask the receiver for one long hold-off
	int   hold_left = 0;
	int   quiet_cycles = 0;

	pid_controller_pos_inc uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	pidc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off on request so the
	// pipeline fills and back-pressures the sample channel.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[tb] no transfer for %0d cycles", STALL_LIMIT);
				$display("[pid_controller_pos_inc] ERROR");
				$finish;
			end
		end
	end

	// Offer one sample after a random idle gap; hold it until the transfer.
	task automatic send_sample(input logic signed [DATA_WIDTH-1:0] sp,
			input logic signed [DATA_WIDTH-1:0] mv);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid     <= 1'b1;
		sample.setpoint  <= sp;
		sample.measured  <= mv;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Drop valid and wait until every predicted result has come out.
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all registers back to back, plus one write to the unmapped index.
	// Unused upper data bits carry noise that the block must ignore.
	task automatic apply_settings(input pidc_cfg_t c);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KP;
		cfg_data  <= {8'($urandom), c.kp};
		@(negedge clk);
		cfg_index <= REG_KI;
		cfg_data  <= {8'($urandom), c.ki};
		@(negedge clk);
		cfg_index <= REG_KD;
		cfg_data  <= {8'($urandom), c.kd};
		@(negedge clk);
		cfg_index <= REG_OUT_MAX;
		cfg_data  <= c.out_max;
		@(negedge clk);
		cfg_index <= REG_OUT_MIN;
		cfg_data  <= c.out_min;
		@(negedge clk);
		cfg_index <= REG_CLAMP_ENABLE;
		cfg_data  <= {23'($urandom), c.clamp_enable};
		@(negedge clk);
		cfg_index <= REG_MODE;
		cfg_data  <= {23'($urandom), c.mode};
		@(negedge clk);
		cfg_index <= REG_UNMAPPED;
		cfg_data  <= 24'($urandom);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic signed [GAIN_WIDTH-1:0] pick_gain();
		case ($urandom_range(3))
			0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1:       return 16'(int'($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		pidc_cfg_t                    settings;
		logic signed [DATA_WIDTH-1:0] sp, mv;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: incremental form, clamped to +/-1000.
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd100, 16'sd50);
		send_sample(16'sd100, 16'sd90);
		send_sample(-16'sd3, 16'sd4);
		drain();

		// Positional form, unclamped, extreme gains.
		settings.kp           = 16'sh7FFF;
		settings.ki           = 16'sh8000;
		settings.kd           = 16'sh8000;
		settings.out_max      = 24'sd1000;
		settings.out_min      = -24'sd1000;
		settings.clamp_enable = 1'b0;
		settings.mode         = MODE_POSITIONAL;
		apply_settings(settings);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(-16'sd1, 16'sd0);
		drain();

		// Crossed limits: out_min above out_max, so out_min wins.
		settings.kp           = 16'sd256;
		settings.ki           = 16'sd256;
		settings.kd           = 16'sd256;
		settings.out_max      = -24'sd5000;
		settings.out_min      = 24'sd5000;
		settings.clamp_enable = 1'b1;
		settings.mode         = MODE_INCREMENTAL;
		apply_settings(settings);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd20, 16'sd10);
		drain();

		// Integrator windup: push the error sum far enough that the integral
		// term saturates the 32-bit output with the output unclamped, then
		// pull it down past zero to the same depth with the widest limits.
		settings.kp           = 16'sd1;
		settings.ki           = 16'sh7FFF;
		settings.kd           = 16'sd0;
		settings.out_max      = 24'sh7FFFFF;
		settings.out_min      = 24'sh800000;
		settings.clamp_enable = 1'b0;
		settings.mode         = MODE_POSITIONAL;
		apply_settings(settings);
		repeat (WINDUP_UP) send_sample(16'sd32767, -16'sd32768);
		drain();
		settings.clamp_enable = 1'b1;
		apply_settings(settings);
		repeat (WINDUP_DOWN) send_sample(-16'sd32768, 16'sd32767);
		drain();

		// Random phases: new settings and a new idle profile each time.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 70; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 70; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			settings.kp = pick_gain();
			settings.ki = pick_gain();
			settings.kd = pick_gain();
			case ($urandom_range(3))
				0: begin
					settings.out_max = 24'sh7FFFFF;
					settings.out_min = 24'sh800000;
				end
				1: begin
					settings.out_max = 24'(-int'($urandom_range(5000)));
					settings.out_min = 24'($urandom_range(5000));
				end
				2: begin
					settings.out_max = 24'($urandom_range(20000));
					settings.out_min = 24'(-int'($urandom_range(20000)));
				end
				default: begin
					settings.out_max = 24'($urandom);
					settings.out_min = 24'($urandom);
				end
			endcase
			settings.clamp_enable = 1'($urandom_range(1));
			settings.mode         = 1'($urandom_range(1));
			apply_settings(settings);
			if (p == 0) begin
				// Hold off the receiver while samples keep coming.
				@(posedge clk);
				hold_request = 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				case ($urandom_range(7))
					0: begin
						sp = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
						mv = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
					end
					1: begin
						sp = 16'($urandom);
						mv = sp + 16'(int'($urandom_range(64)) - 32);
					end
					default: begin
						sp = 16'($urandom);
						mv = 16'($urandom);
					end
				endcase
				send_sample(sp, mv);
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("[pid_controller_pos_inc] OK");
		else
			$display("[pid_controller_pos_inc] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pidc_pkg.sv
sv/pidc_core.sv
sv/pid_controller_pos_inc.sv
dv/pidc_checker.sv
dv/tb_pid_controller_pos_inc.sv
